// File: design/lns_pkg.sv
// lns_pkg: shared widths, constants, queue entry type and the leading-one search
// for the natural-log unit. No dependencies.
package lns_pkg;

    localparam int X_W         = 32;
    localparam int OUT_W       = 32;
    localparam int P_W         = 5;
    localparam int K_W         = 6;
    localparam int SER_FRAC    = 30;
    localparam int U_W         = 30;
    localparam int RECIP_W     = 31;
    localparam int ACC_W       = 32;
    localparam int V_W         = 38;
    localparam int TC_W        = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [TC_W-1:0] TC_RESET = 6'd32;
    localparam logic [U_W-1:0]  LN2_Q30  = 30'd744261118;

    typedef struct packed {
        logic                  zero;
        logic signed [K_W-1:0] k;
        logic [U_W-1:0]        u;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [P_W-1:0] lead_one(input logic [X_W-1:0] x);
        logic [P_W-1:0] pos;
        pos = '0;
        for (int b = 0; b < X_W; b++)
        begin
            if (x[b])
            begin
                pos = P_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

// File: design/lns_front.sv
// lns_front: accepts operands, finds the leading one and normalizes to a Q0.30 fraction.
// Depends on lns_pkg; pushes entries into lns_queue.
module lns_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lns_pkg::X_W-1:0]      x_value,
    input  lns_pkg::q_stat_t             q_stat,
    output logic                         q_push,
    output lns_pkg::entry_t              q_entry
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_FIND,
        F_NORM
    } fstate_t;

    fstate_t                     state_reg;
    logic [lns_pkg::X_W-1:0]     x_reg;
    logic [lns_pkg::P_W-1:0]     p_reg;
    logic [lns_pkg::X_W-1:0]     m_next;

    assign in_stall = (state_reg != F_IDLE);
    assign q_push   = (state_reg == F_NORM) && !q_stat.full;

    always_comb
    begin
        if (p_reg == lns_pkg::P_W'(lns_pkg::X_W - 1))
        begin
            m_next = x_reg >> 1;
        end
        else
        begin
            m_next = x_reg << (lns_pkg::SER_FRAC - int'(p_reg));
        end
        q_entry.zero = (x_reg == '0);
        q_entry.k    = lns_pkg::K_W'($signed({1'b0, p_reg}) - FRAC_BITS);
        q_entry.u    = m_next[lns_pkg::U_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            x_reg     <= '0;
            p_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg     <= x_value;
                        state_reg <= F_FIND;
                    end
                end
                F_FIND:
                begin
                    p_reg     <= lns_pkg::lead_one(x_reg);
                    state_reg <= F_NORM;
                end
                F_NORM:
                begin
                    if (!q_stat.full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/lns_queue.sv
// lns_queue: short FIFO of normalized operands between front and back.
// Depends on lns_pkg.
module lns_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lns_pkg::entry_t    push_entry,
    input  logic               pop,
    output lns_pkg::entry_t    head,
    output lns_pkg::q_stat_t   stat
);

    localparam int PTR_W = (lns_pkg::QUEUE_DEPTH > 1) ? $clog2(lns_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lns_pkg::QUEUE_DEPTH + 1);

    lns_pkg::entry_t   mem_reg [lns_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == CNT_W'(lns_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(lns_pkg::QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(lns_pkg::QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/lns_back.sv
// lns_back: series evaluation (one term per cycle), k*ln2 add, rounding, saturation, output register.
// Depends on lns_pkg; pops entries from lns_queue.
module lns_back #(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lns_pkg::TC_W-1:0]            term_count,
    input  lns_pkg::q_stat_t                    q_stat,
    input  lns_pkg::entry_t                     q_head,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lns_pkg::OUT_W-1:0]    ln_value,
    output logic                                domain_error
);

    localparam int I_W     = $clog2(MAX_TERMS + 1);
    localparam int SHIFT_W = ($clog2(MAX_TERMS) > 1) ? $clog2($clog2(MAX_TERMS) + 1) : 1;
    localparam int PROD_W  = lns_pkg::U_W + lns_pkg::RECIP_W;
    localparam int V_W     = lns_pkg::V_W;
    localparam int RS      = lns_pkg::SER_FRAC - FRAC_BITS;

    localparam logic signed [V_W-1:0] LN2_V = V_W'(lns_pkg::LN2_Q30);
    localparam logic signed [V_W-1:0] HALF  =
        (RS > 0) ? (V_W'(1) << ((RS > 0) ? RS - 1 : 0)) : '0;
    localparam logic signed [V_W-1:0] SMAX  = (V_W'(1) << (lns_pkg::OUT_W - 1)) - 1;
    localparam logic signed [V_W-1:0] SMIN  = -(V_W'(1) << (lns_pkg::OUT_W - 1));

    typedef enum logic [2:0] {
        B_IDLE,
        B_TERM,
        B_FLUSH,
        B_SUM,
        B_OUT
    } bstate_t;

    // ceil(2^(30+L)/d), L = ceil(log2 d): exact floor(pw/d) for pw < 2^30
    logic [lns_pkg::RECIP_W-1:0] recip_tab [MAX_TERMS + 1];
    logic [SHIFT_W-1:0]          lsh_tab   [MAX_TERMS + 1];

    for (genvar j = 0; j <= MAX_TERMS; j++)
    begin : g_recip
        localparam int unsigned     DIV = (j == 0) ? 1 : j;
        localparam int unsigned     LSH = $clog2(DIV);
        localparam longint unsigned NUM = 64'd1 << (lns_pkg::SER_FRAC + LSH);
        localparam longint unsigned RCP = (NUM + DIV - 1) / DIV;
        assign recip_tab[j] = lns_pkg::RECIP_W'(RCP);
        assign lsh_tab[j]   = SHIFT_W'(LSH);
    end

    bstate_t                           state_reg;
    logic [lns_pkg::U_W-1:0]           u_reg;
    logic [lns_pkg::U_W-1:0]           pw_reg;
    logic signed [lns_pkg::K_W-1:0]    k_reg;
    logic                              zero_reg;
    logic [I_W-1:0]                    i_reg;
    logic [I_W-1:0]                    n_reg;
    logic [PROD_W-1:0]                 prod_reg;
    logic [SHIFT_W-1:0]                lsh_reg;
    logic                              neg_reg;
    logic                              tv_reg;
    logic signed [lns_pkg::ACC_W-1:0]  acc_reg;
    logic signed [V_W-1:0]             v_reg;
    logic                              out_valid_reg;
    logic signed [lns_pkg::OUT_W-1:0]  ln_value_reg;
    logic                              domain_error_reg;

    logic [I_W-1:0]                    n_next;
    logic [2*lns_pkg::U_W-1:0]         pwp;
    logic [lns_pkg::U_W-1:0]           pw_next;
    logic [PROD_W-1:0]                 prod_next;
    logic [lns_pkg::U_W-1:0]           q;
    logic signed [lns_pkg::ACC_W-1:0]  acc_next;
    logic signed [V_W-1:0]             v_next;
    logic signed [V_W-1:0]             r;
    logic signed [lns_pkg::OUT_W-1:0]  sat;
    logic                              out_free;

    assign out_valid    = out_valid_reg;
    assign ln_value     = ln_value_reg;
    assign domain_error = domain_error_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign q_pop        = (state_reg == B_IDLE) && !q_stat.empty;

    always_comb
    begin
        n_next = (8'(term_count) > 8'(MAX_TERMS)) ? I_W'(MAX_TERMS) : I_W'(term_count);

        pwp       = (2*lns_pkg::U_W)'(pw_reg) * (2*lns_pkg::U_W)'(u_reg);
        pw_next   = pwp[2*lns_pkg::U_W-1:lns_pkg::SER_FRAC];
        prod_next = PROD_W'(pw_reg) * PROD_W'(recip_tab[i_reg]);

        q        = lns_pkg::U_W'(prod_reg >> (lns_pkg::SER_FRAC + int'(lsh_reg)));
        acc_next = acc_reg;
        if (tv_reg)
        begin
            if (neg_reg)
            begin
                acc_next = acc_reg - $signed(lns_pkg::ACC_W'(q));
            end
            else
            begin
                acc_next = acc_reg + $signed(lns_pkg::ACC_W'(q));
            end
        end

        v_next = (V_W'(k_reg) * LN2_V) + V_W'(acc_reg);

        r = (v_reg + HALF) >>> RS;
        if (r > SMAX)
        begin
            sat = lns_pkg::OUT_W'(SMAX);
        end
        else if (r < SMIN)
        begin
            sat = lns_pkg::OUT_W'(SMIN);
        end
        else
        begin
            sat = lns_pkg::OUT_W'(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            u_reg            <= '0;
            pw_reg           <= '0;
            k_reg            <= '0;
            zero_reg         <= 1'b0;
            i_reg            <= '0;
            n_reg            <= '0;
            prod_reg         <= '0;
            lsh_reg          <= '0;
            neg_reg          <= 1'b0;
            tv_reg           <= 1'b0;
            acc_reg          <= '0;
            v_reg            <= '0;
            out_valid_reg    <= 1'b0;
            ln_value_reg     <= '0;
            domain_error_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != B_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        u_reg    <= q_head.u;
                        pw_reg   <= q_head.u;
                        k_reg    <= q_head.k;
                        zero_reg <= q_head.zero;
                        i_reg    <= I_W'(1);
                        n_reg    <= n_next;
                        acc_reg  <= '0;
                        tv_reg   <= 1'b0;
                        if (q_head.zero || (n_next == '0))
                        begin
                            state_reg <= B_SUM;
                        end
                        else
                        begin
                            state_reg <= B_TERM;
                        end
                    end
                end
                B_TERM:
                begin
                    acc_reg  <= acc_next;
                    prod_reg <= prod_next;
                    lsh_reg  <= lsh_tab[i_reg];
                    neg_reg  <= !i_reg[0];
                    tv_reg   <= 1'b1;
                    pw_reg   <= pw_next;
                    i_reg    <= i_reg + 1'b1;
                    if (i_reg == n_reg)
                    begin
                        state_reg <= B_FLUSH;
                    end
                end
                B_FLUSH:
                begin
                    acc_reg   <= acc_next;
                    tv_reg    <= 1'b0;
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    v_reg     <= zero_reg ? '0 : v_next;
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        ln_value_reg     <= sat;
                        domain_error_reg <= zero_reg;
                        state_reg        <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_term_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_TERM) |-> (i_reg != '0) && (i_reg <= n_reg))
        else $error("term index out of range");

    a_power_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_TERM) && ($past(state_reg) == B_TERM) |-> (pw_reg <= $past(pw_reg)))
        else $error("series power grew");

    a_acc_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SUM) |-> !acc_reg[lns_pkg::ACC_W-1])
        else $error("series sum negative");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && domain_error) |-> (ln_value == '0))
        else $error("domain error with nonzero result");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != B_IDLE))
        else $error("popped item not started");

endmodule

// File: design/natural_log_series.sv
// natural_log_series: top level, ln of an unsigned Q16.16 operand as signed Q16.16.
// Depends on lns_pkg, lns_front, lns_queue, lns_back.
//
//   channel   direction  handshake                    payload
//   input     in         in_valid / in_stall          x_value
//   output    out        out_valid / out_stall        ln_value, domain_error
//   config    in         term_count_we                term_count
//
// Back end per item, n = min(term_count, MAX_TERMS): one series
// term per cycle through the power and reciprocal multipliers, then sum, round, output.
// Front end captures, finds the leading one, then normalizes and pushes; it runs ahead through a 2-entry queue.
// Zero operand or n = 0 skips the term loop.
// Reset clears control state and sets term_count to 32; no clearing pass.
// A stalled output holds its item while front and queue keep accepting until the queue fills.
module natural_log_series #(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lns_pkg::X_W-1:0]            x_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [lns_pkg::OUT_W-1:0]   ln_value,
    output logic                               domain_error,
    input  logic                               term_count_we,
    input  logic [lns_pkg::TC_W-1:0]           term_count
);

    logic [lns_pkg::TC_W-1:0] term_count_reg;
    lns_pkg::q_stat_t         q_stat;
    lns_pkg::entry_t          q_entry;
    lns_pkg::entry_t          q_head;
    logic                     q_push;
    logic                     q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= lns_pkg::TC_RESET;
        end
        else if (term_count_we)
        begin
            term_count_reg <= term_count;
        end
    end

    lns_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .x_value  (x_value),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    lns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    lns_back #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .term_count   (term_count_reg),
        .q_stat       (q_stat),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ln_value     (ln_value),
        .domain_error (domain_error)
    );

endmodule
